>>> hw/rtl/bbc_pkg.sv
`default_nettype none

package bbc_pkg;

   // characters the scanner reacts to
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_RBRACK = 8'h5D;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;

   localparam int NUM_COUNTERS    = 6;
   localparam int OUT_COUNT_WIDTH = 16;

   // counter slots
   localparam int CNT_OPEN_PAREN    = 0;
   localparam int CNT_CLOSE_PAREN   = 1;
   localparam int CNT_OPEN_BRACKET  = 2;
   localparam int CNT_CLOSE_BRACKET = 3;
   localparam int CNT_OPEN_BRACE    = 4;
   localparam int CNT_CLOSE_BRACE   = 5;

   typedef enum logic [2:0] {
      MODE_CODE     = 3'd0,
      MODE_SLASH    = 3'd1,
      MODE_CMT      = 3'd2,
      MODE_CMT_STAR = 3'd3,
      MODE_STR      = 3'd4,
      MODE_STR_ESC  = 3'd5,
      MODE_CHR      = 3'd6,
      MODE_CHR_ESC  = 3'd7
   } mode_type;

   typedef enum logic [1:0] {
      STAT_BALANCED      = 2'd0,
      STAT_MISSING_OPEN  = 2'd1,
      STAT_MISSING_CLOSE = 2'd2
   } status_type;

   // classified byte handed from front to back
   typedef struct packed {
      logic [NUM_COUNTERS-1:0] bump;
      logic                    last;
   } token_type;

endpackage

`default_nettype wire

>>> hw/rtl/bbc_channels.sv
`default_nettype none

interface bbc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       last_byte;

   modport source (output valid, output text_byte, output last_byte, input ready);
   modport sink (input valid, input text_byte, input last_byte, output ready);
   modport monitor (input valid, input ready, input text_byte, input last_byte);
endinterface

interface bbc_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] open_paren_count;
   logic [15:0] close_paren_count;
   logic [15:0] open_bracket_count;
   logic [15:0] close_bracket_count;
   logic [15:0] open_brace_count;
   logic [15:0] close_brace_count;
   logic [1:0]  paren_status;
   logic [1:0]  bracket_status;
   logic [1:0]  brace_status;
   logic        text_done;

   modport source (
      output valid, input ready,
      output open_paren_count, output close_paren_count,
      output open_bracket_count, output close_bracket_count,
      output open_brace_count, output close_brace_count,
      output paren_status, output bracket_status, output brace_status,
      output text_done
   );
   modport sink (
      input valid, output ready,
      input open_paren_count, input close_paren_count,
      input open_bracket_count, input close_bracket_count,
      input open_brace_count, input close_brace_count,
      input paren_status, input bracket_status, input brace_status,
      input text_done
   );
   modport monitor (
      input valid, input ready,
      input open_paren_count, input close_paren_count,
      input open_bracket_count, input close_bracket_count,
      input open_brace_count, input close_brace_count,
      input paren_status, input bracket_status, input brace_status,
      input text_done
   );
endinterface

`default_nettype wire

>>> hw/rtl/bbc_front.sv
`default_nettype none

module bbc_front (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          in_valid,
   output logic               in_ready,
   input  wire logic [7:0]    in_byte,
   input  wire logic          in_last,
   input  wire logic          q_full,
   output logic               q_push,
   output bbc_pkg::token_type q_token
);
   import bbc_pkg::*;

   mode_type                mode_ff;
   mode_type                mode_in;
   mode_type                mode_nx;
   logic [NUM_COUNTERS-1:0] bump;
   logic                    accept;

   function automatic mode_type code_next(input logic [7:0] b);
      mode_type m;
      case (b)
         CH_SLASH:  m = MODE_SLASH;
         CH_DQUOTE: m = MODE_STR;
         CH_SQUOTE: m = MODE_CHR;
         default:   m = MODE_CODE;
      endcase
      return m;
   endfunction

   function automatic logic [NUM_COUNTERS-1:0] code_bump(input logic [7:0] b);
      logic [NUM_COUNTERS-1:0] v;
      v = '0;
      case (b)
         CH_LPAREN: v[CNT_OPEN_PAREN]    = 1'b1;
         CH_RPAREN: v[CNT_CLOSE_PAREN]   = 1'b1;
         CH_LBRACK: v[CNT_OPEN_BRACKET]  = 1'b1;
         CH_RBRACK: v[CNT_CLOSE_BRACKET] = 1'b1;
         CH_LBRACE: v[CNT_OPEN_BRACE]    = 1'b1;
         CH_RBRACE: v[CNT_CLOSE_BRACE]   = 1'b1;
         default:   v = '0;
      endcase
      return v;
   endfunction

   assign in_ready = !q_full;
   assign accept   = in_valid && in_ready;

   // next state
   always_comb begin
      unique case (mode_ff)
         MODE_CODE:     mode_nx = code_next(in_byte);
         MODE_SLASH:    mode_nx = (in_byte == CH_STAR) ? MODE_CMT : code_next(in_byte);
         MODE_CMT:      mode_nx = (in_byte == CH_STAR) ? MODE_CMT_STAR : MODE_CMT;
         MODE_CMT_STAR: begin
            if (in_byte == CH_SLASH) mode_nx = MODE_CODE;
            else if (in_byte == CH_STAR) mode_nx = MODE_CMT_STAR;
            else mode_nx = MODE_CMT;
         end
         MODE_STR: begin
            if (in_byte == CH_BSLASH) mode_nx = MODE_STR_ESC;
            else if (in_byte == CH_DQUOTE) mode_nx = MODE_CODE;
            else mode_nx = MODE_STR;
         end
         MODE_STR_ESC:  mode_nx = MODE_STR;
         MODE_CHR: begin
            if (in_byte == CH_BSLASH) mode_nx = MODE_CHR_ESC;
            else if (in_byte == CH_SQUOTE) mode_nx = MODE_CODE;
            else mode_nx = MODE_CHR;
         end
         MODE_CHR_ESC:  mode_nx = MODE_CHR;
         default:       mode_nx = MODE_CODE;
      endcase
   end

   // outputs: which counter this byte bumps
   always_comb begin
      unique case (mode_ff)
         MODE_CODE:  bump = code_bump(in_byte);
         MODE_SLASH: bump = (in_byte == CH_STAR) ? '0 : code_bump(in_byte);
         default:    bump = '0;
      endcase
   end

   assign q_push       = accept;
   assign q_token.bump = bump;
   assign q_token.last = in_last;

   always_comb begin
      mode_in = mode_ff;
      if (accept) begin
         mode_in = in_last ? MODE_CODE : mode_nx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_CODE;
      end else begin
         mode_ff <= mode_in;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/bbc_queue.sv
`default_nettype none

module bbc_queue (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire bbc_pkg::token_type push_token,
   output logic               full,
   input  wire logic          pop,
   output logic               not_empty,
   output bbc_pkg::token_type pop_token
);
   import bbc_pkg::*;

   token_type  slot_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] fill_ff;
   logic [1:0] fill_in;

   assign full      = (fill_ff == 2'd2);
   assign not_empty = (fill_ff != 2'd0);
   assign pop_token = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) fill_in = fill_ff + 2'd1;
      else if (pop && !push) fill_in = fill_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_token;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/bbc_back.sv
`default_nettype none

module bbc_back #(
   parameter int COUNT_WIDTH = 16
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          q_not_empty,
   input  wire bbc_pkg::token_type q_token,
   output logic               q_pop,
   bbc_rsp_if.source          rsp_chan
);
   import bbc_pkg::*;

   logic [COUNT_WIDTH-1:0]     cnt_ff [NUM_COUNTERS];
   logic [COUNT_WIDTH-1:0]     cnt_in [NUM_COUNTERS];
   logic [COUNT_WIDTH-1:0]     cnt_nx [NUM_COUNTERS];
   logic [OUT_COUNT_WIDTH-1:0] out_cnt_ff [NUM_COUNTERS];
   status_type                 paren_st_ff;
   status_type                 bracket_st_ff;
   status_type                 brace_st_ff;
   logic                       done_ff;
   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;

   function automatic status_type pair_status(input logic [COUNT_WIDTH-1:0] opens,
                                              input logic [COUNT_WIDTH-1:0] closes);
      status_type s;
      if (opens < closes) s = STAT_MISSING_OPEN;
      else if (opens > closes) s = STAT_MISSING_CLOSE;
      else s = STAT_BALANCED;
      return s;
   endfunction

   assign q_pop = q_not_empty && (!rsp_valid_ff || rsp_chan.ready);

   // saturating increment
   always_comb begin
      for (int i = 0; i < NUM_COUNTERS; i++) begin
         cnt_nx[i] = cnt_ff[i];
         if (q_token.bump[i] && (cnt_ff[i] != {COUNT_WIDTH{1'b1}})) begin
            cnt_nx[i] = cnt_ff[i] + {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
         end
      end
   end

   always_comb begin
      for (int i = 0; i < NUM_COUNTERS; i++) begin
         cnt_in[i] = cnt_ff[i];
         if (q_pop) cnt_in[i] = q_token.last ? '0 : cnt_nx[i];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (q_pop) rsp_valid_in = 1'b1;
      else if (rsp_chan.ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_COUNTERS; i++) cnt_ff[i] <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < NUM_COUNTERS; i++) cnt_ff[i] <= cnt_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         for (int i = 0; i < NUM_COUNTERS; i++) begin
            out_cnt_ff[i] <= OUT_COUNT_WIDTH'(cnt_nx[i]);
         end
         paren_st_ff   <= pair_status(cnt_nx[CNT_OPEN_PAREN], cnt_nx[CNT_CLOSE_PAREN]);
         bracket_st_ff <= pair_status(cnt_nx[CNT_OPEN_BRACKET], cnt_nx[CNT_CLOSE_BRACKET]);
         brace_st_ff   <= pair_status(cnt_nx[CNT_OPEN_BRACE], cnt_nx[CNT_CLOSE_BRACE]);
         done_ff       <= q_token.last;
      end
   end

   assign rsp_chan.valid               = rsp_valid_ff;
   assign rsp_chan.open_paren_count    = out_cnt_ff[CNT_OPEN_PAREN];
   assign rsp_chan.close_paren_count   = out_cnt_ff[CNT_CLOSE_PAREN];
   assign rsp_chan.open_bracket_count  = out_cnt_ff[CNT_OPEN_BRACKET];
   assign rsp_chan.close_bracket_count = out_cnt_ff[CNT_CLOSE_BRACKET];
   assign rsp_chan.open_brace_count    = out_cnt_ff[CNT_OPEN_BRACE];
   assign rsp_chan.close_brace_count   = out_cnt_ff[CNT_CLOSE_BRACE];
   assign rsp_chan.paren_status        = paren_st_ff;
   assign rsp_chan.bracket_status      = bracket_st_ff;
   assign rsp_chan.brace_status        = brace_st_ff;
   assign rsp_chan.text_done           = done_ff;

endmodule

`default_nettype wire

>>> hw/rtl/bracket_balance_counter.sv
// path: a req transfer goes through a queue slot and then the rsp output register before it shows up as a rsp
// throughput: one byte per cycle while the rsp side takes results, set by the mode update in the front and
//   the counter update in the back, with a two-entry queue between them; a stalled rsp side holds the flow
// reset: synchronous, active high; clears the scan mode, the queue, the six counters and rsp valid
// after a byte flagged last, mode and counters return to their reset values
`default_nettype none

module bracket_balance_counter #(
   parameter int COUNT_WIDTH = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   bbc_req_if.sink   req_chan,
   bbc_rsp_if.source rsp_chan
);
   import bbc_pkg::*;

   // front to queue
   logic      q_push;
   token_type push_token;
   logic      q_full;

   // queue to back
   logic      q_pop;
   logic      q_not_empty;
   token_type pop_token;

   // front: tracks comment, string and char-constant context and decides
   // which counter, if any, the byte bumps; ready only depends on queue space
   bbc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_chan.valid),
      .in_ready (req_chan.ready),
      .in_byte  (req_chan.text_byte),
      .in_last  (req_chan.last_byte),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_token  (push_token)
   );

   // short queue so a stalled rsp side does not block the scanner at once
   bbc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_token (push_token),
      .full       (q_full),
      .pop        (q_pop),
      .not_empty  (q_not_empty),
      .pop_token  (pop_token)
   );

   // back: saturating counters, balance status and the rsp output register;
   // a new token is taken whenever the output register is empty or being drained
   bbc_back #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_token     (pop_token),
      .q_pop       (q_pop),
      .rsp_chan    (rsp_chan)
   );

endmodule

`default_nettype wire

>>> hw/rtl/bbc_checker.sv
`default_nettype none

module bbc_checker #(
   parameter int COUNT_WIDTH = 16
) (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [15:0] open_paren_count,
   input wire logic [15:0] close_paren_count,
   input wire logic [15:0] open_brace_count,
   input wire logic [15:0] close_brace_count,
   input wire logic [1:0]  paren_status,
   input wire logic [1:0]  brace_status,
   input wire logic        text_done
);
   import bbc_pkg::*;

   // stalled rsp keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(open_paren_count) &&
         $stable(close_brace_count) && $stable(text_done))
      else $error("rsp payload changed while stalled");

   // rsp valid drops only after a transfer
   a_rsp_drop: assert property (@(posedge clock) disable iff (reset)
      $fell(rsp_valid) |-> $past(rsp_ready))
      else $error("rsp valid dropped without transfer");

   // paren status agrees with the reported counts
   a_paren_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (COUNT_WIDTH <= 16) |->
         ((paren_status == STAT_BALANCED) ==
             (open_paren_count == close_paren_count)) &&
         ((paren_status == STAT_MISSING_OPEN) ==
             (open_paren_count < close_paren_count)))
      else $error("paren status disagrees with counts");

   // brace status agrees with the reported counts
   a_brace_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (COUNT_WIDTH <= 16) |->
         ((brace_status == STAT_BALANCED) ==
             (open_brace_count == close_brace_count)) &&
         ((brace_status == STAT_MISSING_OPEN) ==
             (open_brace_count < close_brace_count)))
      else $error("brace status disagrees with counts");

   // no rsp right after reset, even if a req transfer happens
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

endmodule

bind bracket_balance_counter bbc_checker #(
   .COUNT_WIDTH (COUNT_WIDTH)
) u_bbc_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .open_paren_count  (rsp_chan.open_paren_count),
   .close_paren_count (rsp_chan.close_paren_count),
   .open_brace_count  (rsp_chan.open_brace_count),
   .close_brace_count (rsp_chan.close_brace_count),
   .paren_status      (rsp_chan.paren_status),
   .brace_status      (rsp_chan.brace_status),
   .text_done         (rsp_chan.text_done)
);

`default_nettype wire

>>> verif/tb_bracket_balance_counter.sv
`timescale 1ns / 100ps

module tb_bracket_balance_counter;
   import bbc_pkg::*;

   // counters inside the block are this wide; reported counts are the low 16 bits
   localparam int CW = 16;
   // generous run limit in clock cycles
   localparam int CYCLE_LIMIT = 1_000_000;
   // cycles allowed after the last expected result before the verdict
   localparam int TAIL_CYCLES = 8;
   // only this many mismatch lines are printed, all of them are counted
   localparam int PRINT_LIMIT = 50;

   // one expected result, field for field as on the rsp channel
   typedef struct {
      logic [15:0] open_paren;
      logic [15:0] close_paren;
      logic [15:0] open_bracket;
      logic [15:0] close_bracket;
      logic [15:0] open_brace;
      logic [15:0] close_brace;
      status_type  paren;
      status_type  bracket;
      status_type  brace;
      logic        done;
   } balance_type;

   logic clock;
   logic reset;

   bbc_req_if req_bus ();
   bbc_rsp_if rsp_bus ();

   bracket_balance_counter #(
      .COUNT_WIDTH(CW)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // results still owed by the block, oldest first
   balance_type expected_balance_q[$];

   // scanner state as the predictor sees it
   mode_type      scan_state;
   logic [CW-1:0] tally [NUM_COUNTERS];

   // idle chances in percent for the two sides
   int unsigned src_idle_pct;
   int unsigned snk_stall_pct;

   int unsigned mismatch_count;
   int unsigned cycle_count;

   // text being assembled by the random generator
   logic [7:0] text_buf[$];

   // clock, period 2 ns
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------------

   function automatic void clear_scan();
      scan_state = MODE_CODE;
      for (int i = 0; i < NUM_COUNTERS; i++) tally[i] = '0;
   endfunction

   // counters stick at all ones
   function automatic void bump_tally(int idx);
      if (tally[idx] != {CW{1'b1}}) tally[idx] = tally[idx] + 1'b1;
   endfunction

   // a byte seen as code, i.e. not completing a comment opener
   function automatic mode_type code_char(logic [7:0] b);
      mode_type nxt;
      nxt = MODE_CODE;
      case (b)
         CH_SLASH:  nxt = MODE_SLASH;
         CH_DQUOTE: nxt = MODE_STR;
         CH_SQUOTE: nxt = MODE_CHR;
         CH_LPAREN: bump_tally(CNT_OPEN_PAREN);
         CH_RPAREN: bump_tally(CNT_CLOSE_PAREN);
         CH_LBRACK: bump_tally(CNT_OPEN_BRACKET);
         CH_RBRACK: bump_tally(CNT_CLOSE_BRACKET);
         CH_LBRACE: bump_tally(CNT_OPEN_BRACE);
         CH_RBRACE: bump_tally(CNT_CLOSE_BRACE);
         default: ;
      endcase
      return nxt;
   endfunction

   // compare on the full counter width
   function automatic status_type pair_state(logic [CW-1:0] opens, logic [CW-1:0] closes);
      if (opens < closes) return STAT_MISSING_OPEN;
      if (opens > closes) return STAT_MISSING_CLOSE;
      return STAT_BALANCED;
   endfunction

   // advances the scanner by one byte and returns the result it must report
   function automatic balance_type predict_balance(logic [7:0] b, logic last);
      balance_type r;
      mode_type nxt;
      case (scan_state)
         MODE_SLASH: begin
            // slash-star opens a comment, even after another slash
            if (b == CH_STAR) nxt = MODE_CMT;
            else nxt = code_char(b);
         end
         MODE_CMT: nxt = (b == CH_STAR) ? MODE_CMT_STAR : MODE_CMT;
         MODE_CMT_STAR: begin
            // any run of stars before the slash closes the comment
            if (b == CH_SLASH) nxt = MODE_CODE;
            else if (b == CH_STAR) nxt = MODE_CMT_STAR;
            else nxt = MODE_CMT;
         end
         MODE_STR: begin
            if (b == CH_BSLASH) nxt = MODE_STR_ESC;
            else if (b == CH_DQUOTE) nxt = MODE_CODE;
            else nxt = MODE_STR;
         end
         MODE_STR_ESC: nxt = MODE_STR;
         MODE_CHR: begin
            if (b == CH_BSLASH) nxt = MODE_CHR_ESC;
            else if (b == CH_SQUOTE) nxt = MODE_CODE;
            else nxt = MODE_CHR;
         end
         MODE_CHR_ESC: nxt = MODE_CHR;
         default: nxt = code_char(b);
      endcase
      scan_state = nxt;

      r.open_paren    = tally[CNT_OPEN_PAREN][15:0];
      r.close_paren   = tally[CNT_CLOSE_PAREN][15:0];
      r.open_bracket  = tally[CNT_OPEN_BRACKET][15:0];
      r.close_bracket = tally[CNT_CLOSE_BRACKET][15:0];
      r.open_brace    = tally[CNT_OPEN_BRACE][15:0];
      r.close_brace   = tally[CNT_CLOSE_BRACE][15:0];
      r.paren   = pair_state(tally[CNT_OPEN_PAREN], tally[CNT_CLOSE_PAREN]);
      r.bracket = pair_state(tally[CNT_OPEN_BRACKET], tally[CNT_CLOSE_BRACKET]);
      r.brace   = pair_state(tally[CNT_OPEN_BRACE], tally[CNT_CLOSE_BRACE]);
      r.done    = last;

      // state returns to reset after the final byte of a text
      if (last) clear_scan();
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // checking
   // ---------------------------------------------------------------------

   task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT)
         $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
   endtask

   // every rsp transfer is compared with the oldest expectation
   always @(posedge clock) begin
      balance_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_balance_q.size() == 0) begin
            report_mismatch("unexpected transfer", 32'd1, 32'd0);
         end else begin
            want = expected_balance_q.pop_front();
            if (rsp_bus.open_paren_count !== want.open_paren)
               report_mismatch("open_paren_count", rsp_bus.open_paren_count, want.open_paren);
            if (rsp_bus.close_paren_count !== want.close_paren)
               report_mismatch("close_paren_count", rsp_bus.close_paren_count,
                               want.close_paren);
            if (rsp_bus.open_bracket_count !== want.open_bracket)
               report_mismatch("open_bracket_count", rsp_bus.open_bracket_count,
                               want.open_bracket);
            if (rsp_bus.close_bracket_count !== want.close_bracket)
               report_mismatch("close_bracket_count", rsp_bus.close_bracket_count,
                               want.close_bracket);
            if (rsp_bus.open_brace_count !== want.open_brace)
               report_mismatch("open_brace_count", rsp_bus.open_brace_count, want.open_brace);
            if (rsp_bus.close_brace_count !== want.close_brace)
               report_mismatch("close_brace_count", rsp_bus.close_brace_count,
                               want.close_brace);
            if (rsp_bus.paren_status !== want.paren)
               report_mismatch("paren_status", rsp_bus.paren_status, want.paren);
            if (rsp_bus.bracket_status !== want.bracket)
               report_mismatch("bracket_status", rsp_bus.bracket_status, want.bracket);
            if (rsp_bus.brace_status !== want.brace)
               report_mismatch("brace_status", rsp_bus.brace_status, want.brace);
            if (rsp_bus.text_done !== want.done)
               report_mismatch("text_done", rsp_bus.text_done, want.done);
         end
      end
   end

   // receiver back-pressure, redrawn every falling edge
   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_bracket_balance_counter: FAIL");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // driving
   // ---------------------------------------------------------------------

   // one byte on the req channel; the expectation is formed at the transfer
   task automatic send_byte(logic [7:0] b, logic last);
      @(negedge clock);
      while ($urandom_range(0, 99) < src_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.text_byte <= b;
      req_bus.last_byte <= last;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      expected_balance_q.push_back(predict_balance(b, last));
   endtask

   // whole string as one text, last flag on its final byte
   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
   endtask

   // sender holds off until every owed result has come back
   task automatic drain_results();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (expected_balance_q.size() != 0) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // random text generator
   // ---------------------------------------------------------------------

   // a byte biased toward the characters the scanner cares about
   function automatic logic [7:0] pick_char();
      case ($urandom_range(0, 15))
         0:  return CH_LPAREN;
         1:  return CH_RPAREN;
         2:  return CH_LBRACK;
         3:  return CH_RBRACK;
         4:  return CH_LBRACE;
         5:  return CH_RBRACE;
         6:  return CH_STAR;
         7:  return CH_SLASH;
         8:  return CH_DQUOTE;
         9:  return CH_SQUOTE;
         10: return CH_BSLASH;
         11: return 8'h61 + 8'($urandom_range(0, 25));
         12: return 8'h20;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // appends one piece of c-like text to text_buf
   function automatic void add_fragment();
      int n;
      case ($urandom_range(0, 9))
         0, 1, 2: begin
            // bare bracket character
            case ($urandom_range(0, 5))
               0: text_buf.push_back(CH_LPAREN);
               1: text_buf.push_back(CH_RPAREN);
               2: text_buf.push_back(CH_LBRACK);
               3: text_buf.push_back(CH_RBRACK);
               4: text_buf.push_back(CH_LBRACE);
               default: text_buf.push_back(CH_RBRACE);
            endcase
         end
         3: begin
            // block comment closed by a run of stars
            text_buf.push_back(CH_SLASH);
            text_buf.push_back(CH_STAR);
            n = $urandom_range(0, 6);
            repeat (n) text_buf.push_back(pick_char());
            n = $urandom_range(1, 3);
            repeat (n) text_buf.push_back(CH_STAR);
            text_buf.push_back(CH_SLASH);
         end
         4: begin
            // string with escapes
            text_buf.push_back(CH_DQUOTE);
            n = $urandom_range(0, 6);
            repeat (n) begin
               if ($urandom_range(0, 3) == 0) text_buf.push_back(CH_BSLASH);
               text_buf.push_back(pick_char());
            end
            text_buf.push_back(CH_DQUOTE);
         end
         5: begin
            // character constant, escaped or plain
            text_buf.push_back(CH_SQUOTE);
            if ($urandom_range(0, 1)) text_buf.push_back(CH_BSLASH);
            text_buf.push_back(pick_char());
            text_buf.push_back(CH_SQUOTE);
         end
         6: begin
            // division, or double slash that still opens a comment
            text_buf.push_back(CH_SLASH);
            if ($urandom_range(0, 1)) begin
               text_buf.push_back(CH_SLASH);
               text_buf.push_back(CH_STAR);
            end else begin
               text_buf.push_back(pick_char());
            end
         end
         7: begin
            n = $urandom_range(1, 4);
            repeat (n) text_buf.push_back(8'h61 + 8'($urandom_range(0, 25)));
         end
         default: text_buf.push_back(8'($urandom_range(0, 255)));
      endcase
   endfunction

   // fills text_buf with one text; some are noise, some end inside a construct
   function automatic void build_text();
      int n;
      text_buf.delete();
      if ($urandom_range(0, 9) == 0) begin
         n = $urandom_range(1, 20);
         repeat (n) text_buf.push_back(8'($urandom_range(0, 255)));
      end else begin
         n = $urandom_range(1, 12);
         repeat (n) add_fragment();
         // cut short so a comment or quote may be left open
         if ($urandom_range(0, 6) == 0) begin
            n = $urandom_range(1, text_buf.size());
            while (text_buf.size() > n) void'(text_buf.pop_back());
         end
      end
   endfunction

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // status walks through missing opener, balanced and missing closer
   task automatic test_pair_status();
      send_text(")]}([{{");
   endtask

   // star runs before the closing slash, and no new comment right after it
   task automatic test_comments();
      send_text("/**(**/*)");
      send_text("//*[*/");
   endtask

   // escaped quotes inside strings and character constants
   task automatic test_quotes();
      send_text("\"\\\"(\"'\\'']");
      // text ending inside an open string
      send_text("\"(");
   endtask

   // byte extremes outside any construct
   task automatic test_byte_extremes();
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(CH_LBRACE, 1'b1);
   endtask

   // random texts until about n bytes have gone out
   task automatic test_random_texts(int n);
      int sent;
      sent = 0;
      while (sent < n) begin
         build_text();
         foreach (text_buf[i]) send_byte(text_buf[i], i == text_buf.size() - 1);
         sent += text_buf.size();
         // now and then hold off until the block is empty
         if ($urandom_range(0, 19) == 0) drain_results();
      end
      drain_results();
   endtask

   // ---------------------------------------------------------------------
   // sequence
   // ---------------------------------------------------------------------

   initial begin
      reset = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.text_byte = 8'h00;
      req_bus.last_byte = 1'b0;
      rsp_bus.ready     = 1'b0;
      src_idle_pct   = 14;
      snk_stall_pct  = 73;
      mismatch_count = 0;
      cycle_count    = 0;
      clear_scan();

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part under the first idling mix
      test_pair_status();
      test_comments();
      test_quotes();
      test_byte_extremes();
      drain_results();

      // sender rarely idle, receiver mostly stalled
      src_idle_pct  = 14;
      snk_stall_pct = 73;
      test_random_texts(350);

      // and the other way round
      src_idle_pct  = 73;
      snk_stall_pct = 14;
      test_random_texts(350);

      // full rate on both sides
      src_idle_pct  = 0;
      snk_stall_pct = 0;
      test_random_texts(350);

      while (expected_balance_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("tb_bracket_balance_counter: PASS");
      end else begin
         $display("tb_bracket_balance_counter: FAIL");
      end
      $finish;
   end

endmodule
